// ===== design/cms_pkg.sv =====
// shared types and constants for the chunked multi-stack block
// no dependencies; used by cms_ctrl, cms_dp and chunked_multi_stack
package cms_pkg;

	// input field widths
	localparam int ID_IN_W  = 10;
	localparam int DATA_W   = 32;
	localparam int DEPTH_W  = 17;

	// packed stream widths
	localparam int S_TDATA_W = 48;
	localparam int S_TUSER_W = 1;
	localparam int M_TDATA_W = 32;
	localparam int M_TUSER_W = 2;

	// operation codes
	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	// result status codes
	typedef enum logic [1:0] {
		ST_PUSH_OK   = 2'd0,
		ST_POP_OK    = 2'd1,
		ST_POP_EMPTY = 2'd2,
		ST_POOL_FULL = 2'd3
	} status_t;

	// controller to datapath commands
	typedef struct packed {
		logic cap;   // capture the input transfer
		logic clr;   // clear one stack entry
		logic exe;   // commit the operation and load the result
	} dp_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic clr_last;     // clearing pass is on its last entry
		logic out_blocked;  // result register full and not being taken
	} dp_stat_t;

endpackage

// ===== design/cms_ctrl.sv =====
// sequencer for the chunked multi-stack block
// depends on cms_pkg for the command and status structs
module cms_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  cms_pkg::dp_stat_t  stat,
	output cms_pkg::dp_cmd_t   cmd
);

	typedef enum logic [2:0] {
		S_CLR,
		S_IDLE,
		S_IDX,
		S_RED,
		S_RD,
		S_ADR,
		S_WRD,
		S_EXE
	} state_t;

	state_t state_q;
	logic   ready_q;

	// state and registered ready
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			ready_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLR: begin
					if (stat.clr_last) begin
						state_q <= S_IDLE;
						ready_q <= 1'b1;
					end
				end
				S_IDLE: begin
					if (s_tvalid && ready_q) begin
						state_q <= S_IDX;
						ready_q <= 1'b0;
					end
				end
				S_IDX: state_q <= S_RED;
				S_RED: state_q <= S_RD;
				S_RD:  state_q <= S_ADR;
				S_ADR: state_q <= S_WRD;
				S_WRD: state_q <= S_EXE;
				S_EXE: begin
					if (!stat.out_blocked) begin
						state_q <= S_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= S_CLR;
					ready_q <= 1'b0;
				end
			endcase
		end
	end

	// commands to the datapath
	assign s_tready = ready_q;
	assign cmd.cap  = s_tvalid && ready_q;
	assign cmd.clr  = (state_q == S_CLR);
	assign cmd.exe  = (state_q == S_EXE) && !stat.out_blocked;

endmodule

// ===== design/cms_dp.sv =====
// datapath of the chunked multi-stack block: per-stack tables, chunk link
// and word memories, free list registers, result register; uses cms_pkg
module cms_dp #(
	parameter int NUM_STACKS  = 1024,
	parameter int CHUNK_WORDS = 7,
	parameter int NUM_CHUNKS  = 16384
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cms_pkg::dp_cmd_t              cmd,
	output cms_pkg::dp_stat_t             stat,
	input  logic                          in_op,
	input  logic [cms_pkg::ID_IN_W-1:0]   in_id,
	input  logic [cms_pkg::DATA_W-1:0]    in_val,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [cms_pkg::DATA_W-1:0]    out_value,
	output cms_pkg::status_t              out_status
);

	localparam int ID_W   = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
	localparam int SL_W   = (CHUNK_WORDS > 1) ? $clog2(CHUNK_WORDS) : 1;
	localparam int CIW    = $clog2(NUM_CHUNKS);
	localparam int LINK_W = $clog2(NUM_CHUNKS + 1);
	localparam int WORDS  = NUM_CHUNKS * CHUNK_WORDS;
	localparam int WA_W   = $clog2(WORDS);
	localparam int ENT_W  = cms_pkg::DEPTH_W + SL_W;
	localparam int DW     = cms_pkg::DATA_W;

	// chunk number modulo the pool size, for values below twice the size
	function automatic logic [CIW-1:0] red_chunk(input logic [LINK_W-1:0] v);
		logic [LINK_W-1:0] t;
		t = (v >= LINK_W'(NUM_CHUNKS)) ? v - LINK_W'(NUM_CHUNKS) : v;
		return t[CIW-1:0];
	endfunction

	// captured item
	logic                        x_op_q;
	logic [cms_pkg::ID_IN_W-1:0] x_id_q;
	logic [DW-1:0]               x_val_q;
	logic [ID_W-1:0]             idx_q;

	// memory read registers and address stage
	logic [ENT_W-1:0]  ent_rd_q;
	logic [CIW-1:0]    top_rd_q;
	logic [LINK_W-1:0] link_rd_q;
	logic [DW-1:0]     word_rd_q;
	logic [CIW-1:0]    chunk_q;
	logic [WA_W-1:0]   waddr_q;
	logic              fresh_q;

	// free list and control registers
	logic [LINK_W-1:0] free_head_q;
	logic [LINK_W-1:0] free_cnt_q;
	logic [LINK_W-1:0] fill_q;
	logic [ID_W-1:0]   clr_cnt_q;
	logic              out_valid_q;
	logic [DW-1:0]     out_value_q;
	cms_pkg::status_t  out_status_q;

	// memories
	logic [ENT_W-1:0]  stack_mem [NUM_STACKS];
	logic [CIW-1:0]    top_mem   [NUM_STACKS];
	logic [LINK_W-1:0] link_mem  [NUM_CHUNKS];
	logic [DW-1:0]     word_mem  [WORDS];

	// capture the input transfer
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			x_op_q  <= in_op;
			x_id_q  <= in_id;
			x_val_q <= in_val;
		end
	end

	// stack number modulo the stack count
	generate
		if (NUM_STACKS >= (1 << cms_pkg::ID_IN_W)) begin : g_wide
			always_ff @(posedge clk) begin
				idx_q <= ID_W'(x_id_q);
			end
		end else begin : g_recip
			localparam int RK = 2 * cms_pkg::ID_IN_W;
			localparam int RM = ((1 << RK) + NUM_STACKS - 1) / NUM_STACKS;
			localparam int PW = cms_pkg::ID_IN_W + RK + 1;
			logic [PW-1:0]               prod_q;
			logic [cms_pkg::ID_IN_W-1:0] quo;
			logic [31:0]                 rem;
			// quotient by reciprocal, exact for ten-bit inputs
			always_ff @(posedge clk) begin
				prod_q <= PW'(x_id_q) * PW'(RM);
			end
			assign quo = prod_q[RK+cms_pkg::ID_IN_W-1:RK];
			assign rem = 32'(x_id_q) - 32'(quo) * 32'(NUM_STACKS);
			always_ff @(posedge clk) begin
				idx_q <= rem[ID_W-1:0];
			end
		end
	endgenerate

	// fields of the stack entry
	logic [cms_pkg::DEPTH_W-1:0] d;
	logic [SL_W-1:0]             s;
	logic [SL_W-1:0]             pop_slot;
	logic [SL_W-1:0]             push_slot_nx;
	logic                        is_push;
	logic                        need_chunk;

	assign d            = ent_rd_q[ENT_W-1:SL_W];
	assign s            = ent_rd_q[SL_W-1:0];
	assign pop_slot     = (s == '0) ? SL_W'(CHUNK_WORDS - 1) : s - 1'b1;
	assign push_slot_nx = (s == SL_W'(CHUNK_WORDS - 1)) ? '0 : s + 1'b1;
	assign is_push      = (x_op_q == cms_pkg::OP_PUSH);
	assign need_chunk   = is_push && (s == '0);

	// address stage: chunk and word slot
	logic [CIW-1:0]  chunk_sel;
	logic [SL_W-1:0] wslot;

	assign chunk_sel = need_chunk ? red_chunk(free_head_q) : top_rd_q;
	assign wslot     = is_push ? s : pop_slot;

	always_ff @(posedge clk) begin
		chunk_q <= chunk_sel;
		waddr_q <= WA_W'(chunk_sel) * WA_W'(CHUNK_WORDS) + WA_W'(wslot);
		fresh_q <= (LINK_W'(chunk_sel) >= fill_q);
	end

	// commit decode
	logic [LINK_W-1:0] link_val;
	logic              ent_we;
	logic [ENT_W-1:0]  ent_wd;
	logic              top_we;
	logic [CIW-1:0]    top_wd;
	logic              link_we;
	logic [LINK_W-1:0] link_wd;
	logic              word_we;
	logic              take;
	logic              give;
	logic [DW-1:0]     res_val;
	cms_pkg::status_t  res_stat;

	// a chunk never handed out has no link written yet; its link is taken as the next chunk number
	assign link_val = fresh_q ? LINK_W'(chunk_q) + 1'b1 : link_rd_q;

	always_comb begin
		ent_we   = 1'b0;
		ent_wd   = ent_rd_q;
		top_we   = 1'b0;
		top_wd   = chunk_q;
		link_we  = 1'b0;
		link_wd  = free_head_q;
		word_we  = 1'b0;
		take     = 1'b0;
		give     = 1'b0;
		res_val  = '0;
		res_stat = cms_pkg::ST_PUSH_OK;
		if (is_push) begin
			if ((d == '1) || (need_chunk && (free_cnt_q == '0))) begin
				res_stat = cms_pkg::ST_POOL_FULL;
			end else begin
				ent_we  = 1'b1;
				ent_wd  = {d + 1'b1, push_slot_nx};
				word_we = 1'b1;
				if (need_chunk) begin
					take    = 1'b1;
					top_we  = 1'b1;
					top_wd  = chunk_q;
					link_we = 1'b1;
					link_wd = LINK_W'(top_rd_q);
				end
			end
		end else begin
			if (d == '0) begin
				res_stat = cms_pkg::ST_POP_EMPTY;
			end else begin
				res_stat = cms_pkg::ST_POP_OK;
				res_val  = word_rd_q;
				ent_we   = 1'b1;
				ent_wd   = {d - 1'b1, pop_slot};
				if (pop_slot == '0) begin
					give    = 1'b1;
					top_we  = 1'b1;
					top_wd  = red_chunk(link_val);
					link_we = 1'b1;
					link_wd = free_head_q;
				end
			end
		end
	end

	// per-stack depth and slot, cleared after reset
	always_ff @(posedge clk) begin
		if (cmd.clr) begin
			stack_mem[clr_cnt_q] <= '0;
		end else if (cmd.exe && ent_we) begin
			stack_mem[idx_q] <= ent_wd;
		end
		ent_rd_q <= stack_mem[idx_q];
	end

	// per-stack top chunk
	always_ff @(posedge clk) begin
		if (cmd.exe && top_we) begin
			top_mem[idx_q] <= top_wd;
		end
		top_rd_q <= top_mem[idx_q];
	end

	// chunk links
	always_ff @(posedge clk) begin
		if (cmd.exe && link_we) begin
			link_mem[chunk_q] <= link_wd;
		end
		link_rd_q <= link_mem[chunk_q];
	end

	// word storage
	always_ff @(posedge clk) begin
		if (cmd.exe && word_we) begin
			word_mem[waddr_q] <= x_val_q;
		end
		word_rd_q <= word_mem[waddr_q];
	end

	// free list, fill mark and clearing counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q <= '0;
			free_cnt_q  <= LINK_W'(NUM_CHUNKS);
			fill_q      <= '0;
			clr_cnt_q   <= '0;
		end else begin
			if (cmd.clr) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (cmd.exe && take) begin
				free_head_q <= link_val;
				free_cnt_q  <= free_cnt_q - 1'b1;
				if (fresh_q) begin
					fill_q <= fill_q + 1'b1;
				end
			end else if (cmd.exe && give) begin
				free_head_q <= LINK_W'(chunk_q);
				free_cnt_q  <= free_cnt_q + 1'b1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.exe) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exe) begin
			out_value_q  <= res_val;
			out_status_q <= res_stat;
		end
	end

	assign out_valid        = out_valid_q;
	assign out_value        = out_value_q;
	assign out_status       = out_status_q;
	assign stat.clr_last    = (clr_cnt_q == ID_W'(NUM_STACKS - 1));
	assign stat.out_blocked = out_valid_q && !out_ready;

`ifndef ASSERT_OFF
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		free_cnt_q <= LINK_W'(NUM_CHUNKS))
		else $error("free chunk count above pool size");

	a_fill_cover: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(free_cnt_q) + 32'(fill_q)) >= 32'(NUM_CHUNKS))
		else $error("chunks in use exceed chunks ever handed out");

	a_exe_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exe |-> !(out_valid_q && !out_ready))
		else $error("commit while result register is blocked");

	a_exe_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exe |=> out_valid_q)
		else $error("commit did not load a result");

	a_cap_clr: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cap |-> !cmd.clr)
		else $error("input taken during clearing pass");
`endif

endmodule

// ===== design/chunked_multi_stack.sv =====
// Chunked multi-stack: NUM_STACKS LIFO stacks of 32-bit words sharing a pool
// of NUM_CHUNKS chunks of CHUNK_WORDS words. Each input transfer is one push
// or pop and gives exactly one result transfer. After reset the block runs a
// clearing pass over the per-stack depth table before s_tready first rises.
// An input passes the capture register and the stack number stage, then the
// synchronous reads of the depth and top tables, the address stage and the
// synchronous reads of the link and word memories, and its commit write loads
// the result register. The next input is taken no earlier than the cycle
// after the result is loaded, so one item is in flight at a time. A result
// still waiting on m_tready holds back the commit of the next item, which
// delays that item by the length of that stall.
// Depends on cms_pkg, cms_ctrl and cms_dp.
module chunked_multi_stack #(
	parameter int NUM_STACKS  = 1024,
	parameter int CHUNK_WORDS = 7,
	parameter int NUM_CHUNKS  = 16384
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// stack_id [9:0], push_value [41:10], zero [47:42]
	input  logic [cms_pkg::S_TDATA_W-1:0]   s_tdata,
	// operation [0]
	input  logic [cms_pkg::S_TUSER_W-1:0]   s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// pop_value [31:0]
	output logic [cms_pkg::M_TDATA_W-1:0]   m_tdata,
	// status [1:0]
	output logic [cms_pkg::M_TUSER_W-1:0]   m_tuser
);

	cms_pkg::dp_cmd_t  cmd;
	cms_pkg::dp_stat_t stat;
	cms_pkg::status_t  status;

	// sequencer
	cms_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// tables, memories and result register
	cms_dp #(
		.NUM_STACKS  (NUM_STACKS),
		.CHUNK_WORDS (CHUNK_WORDS),
		.NUM_CHUNKS  (NUM_CHUNKS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_op      (s_tuser[0]),
		.in_id      (s_tdata[cms_pkg::ID_IN_W-1:0]),
		.in_val     (s_tdata[cms_pkg::ID_IN_W+cms_pkg::DATA_W-1:cms_pkg::ID_IN_W]),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_value  (m_tdata),
		.out_status (status)
	);

	assign m_tuser = status;

endmodule
